// ===== hw/rtl/gaq_pkg.sv =====
// Shared types, constants and register codes for the gamepad input qualifier.
package gaq_pkg;

    localparam int NUM_BUTTONS  = 24;
    localparam int COUNT_WIDTH  = 16;
    localparam int BTN_IDX_W    = $clog2(NUM_BUTTONS);
    localparam int WORD_BUTTONS = 14;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int SAMPLE_W     = 16;
    localparam int SQUARE_W     = 2 * SAMPLE_W;

    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_DEAD_ZONE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_DEAD_ZONE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_THRESHOLD   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DELAY        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_PERIOD       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION_THRESHOLD = 3'd5;

    localparam logic [15:0] RST_LEFT_DEAD_ZONE      = 16'd7849;
    localparam logic [15:0] RST_RIGHT_DEAD_ZONE     = 16'd8689;
    localparam logic [7:0]  RST_TRIGGER_THRESHOLD   = 8'd30;
    localparam logic [15:0] RST_REPEAT_DELAY        = 16'd20;
    localparam logic [15:0] RST_REPEAT_PERIOD       = 16'd3;
    localparam logic [14:0] RST_DIRECTION_THRESHOLD = 15'd16384;

    // Bit positions in the button word of logical buttons 0 to 13.
    localparam logic [3:0] WORD_BIT_POS [WORD_BUTTONS] = '{
        4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6,
        4'd7, 4'd8, 4'd9, 4'd12, 4'd13, 4'd14, 4'd15
    };

    localparam int BTN_LS_UP    = 14;
    localparam int BTN_LS_DOWN  = 15;
    localparam int BTN_LS_LEFT  = 16;
    localparam int BTN_LS_RIGHT = 17;
    localparam int BTN_RS_UP    = 18;
    localparam int BTN_RS_DOWN  = 19;
    localparam int BTN_RS_LEFT  = 20;
    localparam int BTN_RS_RIGHT = 21;
    localparam int BTN_LT       = 22;
    localparam int BTN_RT       = 23;

    typedef struct packed {
        logic        connected;
        logic [15:0] button_word;
        logic signed [15:0] left_x;
        logic signed [15:0] left_y;
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
        logic [7:0]  left_pull;
        logic [7:0]  right_pull;
    } gaq_in_t;

    typedef struct packed {
        logic        link_up;
        logic [23:0] held_mask;
        logic [23:0] pressed_mask;
        logic [23:0] released_mask;
        logic [23:0] repeat_mask;
        logic signed [15:0] left_stick_x;
        logic signed [15:0] left_stick_y;
        logic signed [15:0] right_stick_x;
        logic signed [15:0] right_stick_y;
        logic [7:0]  left_level;
        logic [7:0]  right_level;
    } gaq_out_t;

    typedef struct packed {
        logic busy;
        logic done;
    } gaq_div_status_t;

endpackage

// ===== hw/rtl/gaq_square.sv =====
// Registered squarer shared by both sticks and both dead-zone radii.
module gaq_square (
    input  logic                              clk,
    input  logic [gaq_pkg::SAMPLE_W-1:0]      operand,
    output logic [gaq_pkg::SQUARE_W-1:0]      square
);

    logic [gaq_pkg::SQUARE_W-1:0] square_reg;

    always_ff @(posedge clk)
    begin
        square_reg <= operand * operand;
    end

    assign square = square_reg;

endmodule

// ===== hw/rtl/gaq_remainder.sv =====
// Bit-serial remainder unit used for the auto-repeat period check.
module gaq_remainder (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [gaq_pkg::COUNT_WIDTH-1:0]      dividend,
    input  logic [gaq_pkg::COUNT_WIDTH-1:0]      divisor,
    output logic [gaq_pkg::COUNT_WIDTH-1:0]      remainder,
    output gaq_pkg::gaq_div_status_t             status
);

    localparam int CNT_W = $clog2(gaq_pkg::COUNT_WIDTH);

    logic                              active_reg;
    logic                              done_reg;
    logic [CNT_W-1:0]                  cnt_reg;
    logic [gaq_pkg::COUNT_WIDTH-1:0]   quo_reg;
    logic [gaq_pkg::COUNT_WIDTH-1:0]   div_reg;
    logic [gaq_pkg::COUNT_WIDTH-1:0]   rem_reg;
    logic [gaq_pkg::COUNT_WIDTH:0]     trial;
    logic [gaq_pkg::COUNT_WIDTH:0]     diff;
    logic [gaq_pkg::COUNT_WIDTH-1:0]   rem_next;

    always_comb
    begin
        trial = {rem_reg, quo_reg[gaq_pkg::COUNT_WIDTH-1]};
        diff  = trial - {1'b0, div_reg};
        if (trial >= {1'b0, div_reg})
        begin
            rem_next = diff[gaq_pkg::COUNT_WIDTH-1:0];
        end
        else
        begin
            rem_next = trial[gaq_pkg::COUNT_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                active_reg <= 1'b1;
                cnt_reg    <= '0;
            end
            else if (active_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(gaq_pkg::COUNT_WIDTH - 1))
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            div_reg <= divisor;
            rem_reg <= '0;
        end
        else if (active_reg)
        begin
            quo_reg <= {quo_reg[gaq_pkg::COUNT_WIDTH-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign remainder   = rem_reg;
    assign status.busy = active_reg;
    assign status.done = done_reg;

endmodule

// ===== hw/rtl/gamepad_input_qualifier.sv =====
// Top level of the gamepad input qualifier: sequencer, state and result register.
// After a poll is accepted, the shared registered squarer serves the two dead-zone tests,
// then the hold counters are updated, the buttons are scanned in turn and the result
// register is loaded. During the scan, each button whose hold count is above both one and
// repeat_delay also waits on the bit-serial remainder unit. The block is ready again the
// cycle after the result is loaded, so a new poll is not taken while the previous one is
// still being qualified. A new poll is taken once the previous one has been placed in the
// result register, even if that result has not yet been taken; the new result then
// waits in the sequencer until the result register is free.
module gamepad_input_qualifier (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [gaq_pkg::CFG_IDX_W-1:0]       wr_index,
    input  logic [gaq_pkg::CFG_DATA_W-1:0]      wr_data,
    input  logic                                poll_valid,
    output logic                                poll_ready,
    input  gaq_pkg::gaq_in_t                    poll,
    output logic                                result_valid,
    input  logic                                result_ready,
    output gaq_pkg::gaq_out_t                   result
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SQUARE = 3'd1;
    localparam logic [2:0] ST_UPDATE = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_DIVIDE = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    localparam int NB  = gaq_pkg::NUM_BUTTONS;
    localparam int CW  = gaq_pkg::COUNT_WIDTH;
    localparam int IW  = gaq_pkg::BTN_IDX_W;
    localparam int SW  = gaq_pkg::SQUARE_W;

    logic [15:0]  left_dz_reg;
    logic [15:0]  right_dz_reg;
    logic [7:0]   trig_th_reg;
    logic [15:0]  rep_delay_reg;
    logic [15:0]  rep_period_reg;
    logic [14:0]  dir_th_reg;

    logic [2:0]   state_reg;
    logic [2:0]   state_next;
    logic [2:0]   sq_idx_reg;
    logic [IW-1:0] scan_idx_reg;
    logic [SW-1:0] acc_reg;
    logic         left_out_reg;
    logic         right_out_reg;

    gaq_pkg::gaq_in_t  poll_reg;
    gaq_pkg::gaq_out_t result_reg;
    logic              result_valid_reg;

    logic [CW-1:0] hold_count_reg [NB];
    logic [NB-1:0] prev_mask_reg;
    logic [NB-1:0] rep_mask_reg;
    logic signed [15:0] lsx_reg;
    logic signed [15:0] lsy_reg;
    logic signed [15:0] rsx_reg;
    logic signed [15:0] rsy_reg;
    logic [7:0]   llev_reg;
    logic [7:0]   rlev_reg;

    logic [15:0]  sq_operand;
    logic [SW-1:0] sq_value;
    logic [SW-1:0] acc_sum;

    logic signed [15:0] lx_dz;
    logic signed [15:0] ly_dz;
    logic signed [15:0] rx_dz;
    logic signed [15:0] ry_dz;
    logic [7:0]   l_level;
    logic [7:0]   r_level;
    logic signed [16:0] th_pos;
    logic signed [16:0] th_neg;
    logic [NB-1:0] pressed_vec;
    logic [NB-1:0] held_vec;

    logic [CW-1:0] cur_count;
    logic          simple_fire;
    logic          need_div;
    logic [CW-1:0] div_dividend;
    logic [CW-1:0] div_divisor;
    logic [CW-1:0] div_rem;
    logic          div_start;
    gaq_pkg::gaq_div_status_t div_status;
    logic          accept;
    logic          last_button;

    function automatic logic [15:0] magnitude(input logic signed [15:0] v);
        logic [15:0] neg;
        neg = 16'(-v);
        return v[15] ? neg : v;
    endfunction

    assign accept     = poll_valid && poll_ready;
    assign poll_ready = (state_reg == ST_IDLE);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_dz_reg    <= gaq_pkg::RST_LEFT_DEAD_ZONE;
            right_dz_reg   <= gaq_pkg::RST_RIGHT_DEAD_ZONE;
            trig_th_reg    <= gaq_pkg::RST_TRIGGER_THRESHOLD;
            rep_delay_reg  <= gaq_pkg::RST_REPEAT_DELAY;
            rep_period_reg <= gaq_pkg::RST_REPEAT_PERIOD;
            dir_th_reg     <= gaq_pkg::RST_DIRECTION_THRESHOLD;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                gaq_pkg::CFG_LEFT_DEAD_ZONE:      left_dz_reg    <= wr_data;
                gaq_pkg::CFG_RIGHT_DEAD_ZONE:     right_dz_reg   <= wr_data;
                gaq_pkg::CFG_TRIGGER_THRESHOLD:   trig_th_reg    <= wr_data[7:0];
                gaq_pkg::CFG_REPEAT_DELAY:        rep_delay_reg  <= wr_data;
                gaq_pkg::CFG_REPEAT_PERIOD:       rep_period_reg <= wr_data;
                gaq_pkg::CFG_DIRECTION_THRESHOLD: dir_th_reg     <= wr_data[14:0];
                default:                          ;
            endcase
        end
    end

    // Squarer operand order: left x, left y, left radius, right x, right y, right radius.
    always_comb
    begin
        case (sq_idx_reg)
            3'd0:    sq_operand = magnitude(poll_reg.left_x);
            3'd1:    sq_operand = magnitude(poll_reg.left_y);
            3'd2:    sq_operand = left_dz_reg;
            3'd3:    sq_operand = magnitude(poll_reg.right_x);
            3'd4:    sq_operand = magnitude(poll_reg.right_y);
            3'd5:    sq_operand = right_dz_reg;
            default: sq_operand = '0;
        endcase
    end

    gaq_square u_square (
        .clk     (clk),
        .operand (sq_operand),
        .square  (sq_value)
    );

    assign acc_sum = acc_reg + sq_value;

    always_comb
    begin
        lx_dz  = (poll_reg.connected && left_out_reg)  ? poll_reg.left_x  : 16'sd0;
        ly_dz  = (poll_reg.connected && left_out_reg)  ? poll_reg.left_y  : 16'sd0;
        rx_dz  = (poll_reg.connected && right_out_reg) ? poll_reg.right_x : 16'sd0;
        ry_dz  = (poll_reg.connected && right_out_reg) ? poll_reg.right_y : 16'sd0;
        l_level = (poll_reg.connected && poll_reg.left_pull >= trig_th_reg)
                  ? 8'(poll_reg.left_pull - trig_th_reg) : 8'd0;
        r_level = (poll_reg.connected && poll_reg.right_pull >= trig_th_reg)
                  ? 8'(poll_reg.right_pull - trig_th_reg) : 8'd0;
        th_pos = $signed({2'b00, dir_th_reg});
        th_neg = -th_pos;

        pressed_vec = '0;
        for (int i = 0; i < gaq_pkg::WORD_BUTTONS; i++)
        begin
            pressed_vec[i] = poll_reg.button_word[gaq_pkg::WORD_BIT_POS[i]];
        end
        pressed_vec[gaq_pkg::BTN_LS_UP]    = 17'(ly_dz) > th_pos;
        pressed_vec[gaq_pkg::BTN_LS_DOWN]  = 17'(ly_dz) < th_neg;
        pressed_vec[gaq_pkg::BTN_LS_LEFT]  = 17'(lx_dz) < th_neg;
        pressed_vec[gaq_pkg::BTN_LS_RIGHT] = 17'(lx_dz) > th_pos;
        pressed_vec[gaq_pkg::BTN_RS_UP]    = 17'(ry_dz) > th_pos;
        pressed_vec[gaq_pkg::BTN_RS_DOWN]  = 17'(ry_dz) < th_neg;
        pressed_vec[gaq_pkg::BTN_RS_LEFT]  = 17'(rx_dz) < th_neg;
        pressed_vec[gaq_pkg::BTN_RS_RIGHT] = 17'(rx_dz) > th_pos;
        pressed_vec[gaq_pkg::BTN_LT]       = l_level != 8'd0;
        pressed_vec[gaq_pkg::BTN_RT]       = r_level != 8'd0;

        for (int i = 0; i < NB; i++)
        begin
            held_vec[i] = hold_count_reg[i] != '0;
        end
    end

    always_comb
    begin
        cur_count    = hold_count_reg[scan_idx_reg];
        simple_fire  = (cur_count == CW'(1))
                       || ((cur_count != '0) && (cur_count == rep_delay_reg));
        need_div     = (cur_count > CW'(1)) && (cur_count > rep_delay_reg);
        div_dividend = cur_count - rep_delay_reg;
        div_divisor  = (rep_period_reg == '0) ? CW'(1) : rep_period_reg;
        div_start    = (state_reg == ST_SCAN) && need_div;
        last_button  = (scan_idx_reg == IW'(NB - 1));
    end

    gaq_remainder u_remainder (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .remainder (div_rem),
        .status    (div_status)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                if (sq_idx_reg == 3'd6)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (need_div)
                begin
                    state_next = ST_DIVIDE;
                end
                else if (last_button)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_DIVIDE:
            begin
                if (div_status.done)
                begin
                    state_next = last_button ? ST_FINISH : ST_SCAN;
                end
            end
            ST_FINISH:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and button state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            sq_idx_reg       <= '0;
            scan_idx_reg     <= '0;
            result_valid_reg <= 1'b0;
            prev_mask_reg    <= '0;
            for (int i = 0; i < NB; i++)
            begin
                hold_count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_FINISH && (!result_valid_reg || result_ready))
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
            if (accept)
            begin
                sq_idx_reg <= '0;
            end
            else if (state_reg == ST_SQUARE)
            begin
                sq_idx_reg <= sq_idx_reg + 1'b1;
            end
            if (state_reg == ST_UPDATE)
            begin
                scan_idx_reg  <= '0;
                prev_mask_reg <= held_vec;
                if (poll_reg.connected)
                begin
                    for (int i = 0; i < NB; i++)
                    begin
                        if (!pressed_vec[i])
                        begin
                            hold_count_reg[i] <= '0;
                        end
                        else if (hold_count_reg[i] != '1)
                        begin
                            hold_count_reg[i] <= hold_count_reg[i] + 1'b1;
                        end
                    end
                end
            end
            if ((state_reg == ST_SCAN && !need_div)
                || (state_reg == ST_DIVIDE && div_status.done))
            begin
                if (!last_button)
                begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                end
            end
        end
    end

    // Working data path.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            poll_reg <= poll;
        end
        if (state_reg == ST_SQUARE)
        begin
            case (sq_idx_reg)
                3'd1:    acc_reg       <= sq_value;
                3'd2:    acc_reg       <= acc_sum;
                3'd3:    left_out_reg  <= acc_reg >= sq_value;
                3'd4:    acc_reg       <= sq_value;
                3'd5:    acc_reg       <= acc_sum;
                3'd6:    right_out_reg <= acc_reg >= sq_value;
                default: ;
            endcase
        end
        if (state_reg == ST_UPDATE)
        begin
            lsx_reg      <= lx_dz;
            lsy_reg      <= ly_dz;
            rsx_reg      <= rx_dz;
            rsy_reg      <= ry_dz;
            llev_reg     <= l_level;
            rlev_reg     <= r_level;
            rep_mask_reg <= '0;
        end
        if (state_reg == ST_SCAN && !need_div)
        begin
            rep_mask_reg[scan_idx_reg] <= simple_fire;
        end
        if (state_reg == ST_DIVIDE && div_status.done)
        begin
            rep_mask_reg[scan_idx_reg] <= (div_rem == '0);
        end
        if (state_reg == ST_FINISH && (!result_valid_reg || result_ready))
        begin
            result_reg.link_up       <= poll_reg.connected;
            result_reg.held_mask     <= held_vec;
            result_reg.pressed_mask  <= held_vec & ~prev_mask_reg;
            result_reg.released_mask <= prev_mask_reg & ~held_vec;
            result_reg.repeat_mask   <= rep_mask_reg;
            result_reg.left_stick_x  <= lsx_reg;
            result_reg.left_stick_y  <= lsy_reg;
            result_reg.right_stick_x <= rsx_reg;
            result_reg.right_stick_y <= rsy_reg;
            result_reg.left_level    <= llev_reg;
            result_reg.right_level   <= rlev_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_divide_active: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE) |-> (div_status.busy || div_status.done))
        else $error("remainder unit idle while the sequencer waits on it");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> ($past(state_reg) == ST_FINISH))
        else $error("result raised outside the finishing step");

    a_edges_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> ((result_reg.pressed_mask & result_reg.released_mask) == '0))
        else $error("a button is reported both pressed and released");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN || state_reg == ST_DIVIDE) |-> (scan_idx_reg < IW'(NB)))
        else $error("button scan index out of range");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the gamepad input qualifier, with directed and random polls.
`timescale 1ns / 100ps

module tb;

    localparam int CLK_PERIOD   = 12;
    localparam int STALL_LIMIT  = 12000;
    localparam int DRAIN_CYCLES = 500;
    localparam int HOLD_OFF     = 1500;

    localparam logic [gaq_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [gaq_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    logic                           clk          = 1'b0;
    logic                           rst_n        = 1'b0;
    logic                           wr_en        = 1'b0;
    logic [gaq_pkg::CFG_IDX_W-1:0]  wr_index     = '0;
    logic [gaq_pkg::CFG_DATA_W-1:0] wr_data      = '0;
    logic                           poll_valid   = 1'b0;
    logic                           poll_ready;
    gaq_pkg::gaq_in_t               poll         = '0;
    logic                           result_valid;
    logic                           result_ready = 1'b0;
    gaq_pkg::gaq_out_t              result;

    logic [15:0] left_dz    = gaq_pkg::RST_LEFT_DEAD_ZONE;
    logic [15:0] right_dz   = gaq_pkg::RST_RIGHT_DEAD_ZONE;
    logic [7:0]  trig_thr   = gaq_pkg::RST_TRIGGER_THRESHOLD;
    logic [15:0] rep_delay  = gaq_pkg::RST_REPEAT_DELAY;
    logic [15:0] rep_period = gaq_pkg::RST_REPEAT_PERIOD;
    logic [14:0] dir_thr    = gaq_pkg::RST_DIRECTION_THRESHOLD;
    logic [gaq_pkg::COUNT_WIDTH-1:0] hold_cnt [gaq_pkg::NUM_BUTTONS] = '{default: '0};

    gaq_pkg::gaq_out_t expected_reports [$];
    int                mismatches   = 0;
    bit                steady       = 1'b0;
    int                hold_request = 0;
    gaq_pkg::gaq_in_t  cur          = '0;

    gamepad_input_qualifier dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .poll_valid   (poll_valid),
        .poll_ready   (poll_ready),
        .poll         (poll),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic bit outside_zone(logic signed [15:0] x, logic signed [15:0] y,
                                        logic [15:0] dz);
        longint xs, ys, r;
        xs = x;
        ys = y;
        r = dz;
        return xs * xs + ys * ys >= r * r;
    endfunction

    function automatic logic [7:0] trigger_excess(logic [7:0] pull);
        return (pull >= trig_thr) ? pull - trig_thr : 8'd0;
    endfunction

    function automatic bit repeat_due(logic [gaq_pkg::COUNT_WIDTH-1:0] cnt);
        int c, d, p;
        c = cnt;
        d = rep_delay;
        p = (rep_period == 16'd0) ? 1 : int'(rep_period);
        if (c == 0) return 1'b0;
        if (c == 1) return 1'b1;
        if (c <= d) return c == d;
        return (c - d) % p == 0;
    endfunction

    function automatic gaq_pkg::gaq_out_t qualify_poll(gaq_pkg::gaq_in_t p);
        gaq_pkg::gaq_out_t r;
        logic [gaq_pkg::NUM_BUTTONS-1:0] press;
        int lx, ly, rx, ry, th;
        bit was;
        r = '0;
        press = '0;
        r.link_up = p.connected;
        if (p.connected)
        begin
            if (outside_zone(p.left_x, p.left_y, left_dz))
            begin
                r.left_stick_x = p.left_x;
                r.left_stick_y = p.left_y;
            end
            if (outside_zone(p.right_x, p.right_y, right_dz))
            begin
                r.right_stick_x = p.right_x;
                r.right_stick_y = p.right_y;
            end
            r.left_level = trigger_excess(p.left_pull);
            r.right_level = trigger_excess(p.right_pull);
        end
        lx = $signed(r.left_stick_x);
        ly = $signed(r.left_stick_y);
        rx = $signed(r.right_stick_x);
        ry = $signed(r.right_stick_y);
        th = dir_thr;
        for (int i = 0; i < gaq_pkg::WORD_BUTTONS; i++)
            press[i] = p.button_word[gaq_pkg::WORD_BIT_POS[i]];
        press[gaq_pkg::BTN_LS_UP]    = ly > th;
        press[gaq_pkg::BTN_LS_DOWN]  = ly < -th;
        press[gaq_pkg::BTN_LS_LEFT]  = lx < -th;
        press[gaq_pkg::BTN_LS_RIGHT] = lx > th;
        press[gaq_pkg::BTN_RS_UP]    = ry > th;
        press[gaq_pkg::BTN_RS_DOWN]  = ry < -th;
        press[gaq_pkg::BTN_RS_LEFT]  = rx < -th;
        press[gaq_pkg::BTN_RS_RIGHT] = rx > th;
        press[gaq_pkg::BTN_LT]       = r.left_level != 8'd0;
        press[gaq_pkg::BTN_RT]       = r.right_level != 8'd0;
        for (int i = 0; i < gaq_pkg::NUM_BUTTONS; i++)
        begin
            was = hold_cnt[i] != '0;
            if (p.connected)
            begin
                if (!press[i]) hold_cnt[i] = '0;
                else if (hold_cnt[i] != '1) hold_cnt[i] = hold_cnt[i] + 1'b1;
            end
            r.held_mask[i]     = hold_cnt[i] != '0;
            r.pressed_mask[i]  = r.held_mask[i] && !was;
            r.released_mask[i] = was && !r.held_mask[i];
            r.repeat_mask[i]   = repeat_due(hold_cnt[i]);
        end
        return r;
    endfunction

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
        end
    endtask

    task automatic check_report(gaq_pkg::gaq_out_t got);
        gaq_pkg::gaq_out_t want;
        if (expected_reports.size() == 0)
        begin
            mismatches++;
            $display("%0t: result beat expected none actual %h", $time, got);
            return;
        end
        want = expected_reports.pop_front();
        compare_field("link_up", 32'(want.link_up), 32'(got.link_up));
        compare_field("held_mask", 32'(want.held_mask), 32'(got.held_mask));
        compare_field("pressed_mask", 32'(want.pressed_mask), 32'(got.pressed_mask));
        compare_field("released_mask", 32'(want.released_mask), 32'(got.released_mask));
        compare_field("repeat_mask", 32'(want.repeat_mask), 32'(got.repeat_mask));
        compare_field("left_stick_x", 32'(want.left_stick_x), 32'(got.left_stick_x));
        compare_field("left_stick_y", 32'(want.left_stick_y), 32'(got.left_stick_y));
        compare_field("right_stick_x", 32'(want.right_stick_x), 32'(got.right_stick_x));
        compare_field("right_stick_y", 32'(want.right_stick_y), 32'(got.right_stick_y));
        compare_field("left_level", 32'(want.left_level), 32'(got.left_level));
        compare_field("right_level", 32'(want.right_level), 32'(got.right_level));
    endtask

    function automatic int pick_gap();
        int roll;
        if (steady) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 16);
        return $urandom_range(40, 150);
    endfunction

    function automatic gaq_pkg::gaq_in_t make_poll(logic conn, logic [15:0] word,
                                          logic signed [15:0] lx, logic signed [15:0] ly,
                                          logic signed [15:0] rx, logic signed [15:0] ry,
                                          logic [7:0] lp, logic [7:0] rp);
        gaq_pkg::gaq_in_t p;
        p.connected   = conn;
        p.button_word = word;
        p.left_x      = lx;
        p.left_y      = ly;
        p.right_x     = rx;
        p.right_y     = ry;
        p.left_pull   = lp;
        p.right_pull  = rp;
        return p;
    endfunction

    task automatic send_poll(gaq_pkg::gaq_in_t p);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            poll_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        poll_valid <= 1'b1;
        poll <= p;
        do @(posedge clk); while (!poll_ready);
        expected_reports.push_back(qualify_poll(p));
    endtask

    task automatic settle();
        poll_valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(logic [gaq_pkg::CFG_IDX_W-1:0] idx,
                             logic [gaq_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        wr_en <= 1'b0;
        unique case (idx)
            gaq_pkg::CFG_LEFT_DEAD_ZONE:      left_dz = data;
            gaq_pkg::CFG_RIGHT_DEAD_ZONE:     right_dz = data;
            gaq_pkg::CFG_TRIGGER_THRESHOLD:   trig_thr = data[7:0];
            gaq_pkg::CFG_REPEAT_DELAY:        rep_delay = data;
            gaq_pkg::CFG_REPEAT_PERIOD:       rep_period = data;
            gaq_pkg::CFG_DIRECTION_THRESHOLD: dir_thr = data[14:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [15:0] ldz, logic [15:0] rdz, logic [15:0] trig,
                              logic [15:0] delay, logic [15:0] period, logic [15:0] dir);
        write_reg(gaq_pkg::CFG_LEFT_DEAD_ZONE, ldz);
        write_reg(gaq_pkg::CFG_RIGHT_DEAD_ZONE, rdz);
        write_reg(gaq_pkg::CFG_TRIGGER_THRESHOLD, trig);
        write_reg(gaq_pkg::CFG_REPEAT_DELAY, delay);
        write_reg(gaq_pkg::CFG_REPEAT_PERIOD, period);
        write_reg(gaq_pkg::CFG_DIRECTION_THRESHOLD, dir);
    endtask

    task automatic pick_stick(input logic [15:0] dz,
                              output logic signed [15:0] x, output logic signed [15:0] y);
        int v;
        logic signed [15:0] t;
        x = 16'($urandom);
        y = 16'($urandom);
        case ($urandom_range(0, 9))
            0:
            begin
                x = '0;
                y = '0;
            end
            1, 2:
            begin
                v = int'(dz) + int'($urandom_range(0, 2)) - 1;
                if (v > 32767) v = 32767;
                x = 16'(v);
                y = '0;
            end
            3, 4:
            begin
                v = int'(dir_thr) + int'($urandom_range(0, 2)) - 1;
                x = 16'(v);
                y = 16'($urandom_range(0, 255));
            end
            5:
            begin
                x = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                y = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            end
            6, 7:
            begin
                x = 16'(int'($urandom_range(0, 24000)) - 12000);
                y = 16'(int'($urandom_range(0, 24000)) - 12000);
            end
            default: ;
        endcase
        if ($urandom_range(0, 1)) x = -x;
        if ($urandom_range(0, 1))
        begin
            t = x;
            x = y;
            y = t;
        end
    endtask

    function automatic logic [7:0] pick_pull();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd255;
            2, 3: return 8'(int'(trig_thr) + int'($urandom_range(0, 2)) - 1);
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_zone(logic [15:0] dflt);
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'd46341;
            2: return 16'hFFFF;
            3: return dflt;
            default: return 16'($urandom_range(0, 46341));
        endcase
    endfunction

    // Buttons and sticks mostly stay put from poll to poll, so that hold counts grow.
    task automatic evolve_poll();
        int roll;
        cur.connected = ($urandom_range(0, 99) >= 6);
        roll = $urandom_range(0, 99);
        if (roll < 5) cur.button_word = 16'($urandom);
        else if (roll < 25) cur.button_word ^= 16'(1) << $urandom_range(0, 15);
        if ($urandom_range(0, 3) == 0) pick_stick(left_dz, cur.left_x, cur.left_y);
        if ($urandom_range(0, 3) == 0) pick_stick(right_dz, cur.right_x, cur.right_y);
        if ($urandom_range(0, 3) == 0) cur.left_pull = pick_pull();
        if ($urandom_range(0, 3) == 0) cur.right_pull = pick_pull();
    endtask

    task automatic shuffle_config();
        logic [15:0] delay, period;
        logic [7:0]  trig;
        logic [14:0] dir;
        case ($urandom_range(0, 7))
            0: delay = 16'd1;
            1: delay = 16'hFFFF;
            default: delay = 16'($urandom_range(1, 30));
        endcase
        case ($urandom_range(0, 7))
            0: period = 16'd0;
            1: period = 16'hFFFF;
            2: period = 16'd1;
            default: period = 16'($urandom_range(2, 6));
        endcase
        case ($urandom_range(0, 3))
            0: trig = 8'd0;
            1: trig = 8'd255;
            default: trig = 8'($urandom);
        endcase
        case ($urandom_range(0, 3))
            0: dir = 15'd0;
            1: dir = 15'h7FFF;
            default: dir = 15'($urandom);
        endcase
        set_config(pick_zone(gaq_pkg::RST_LEFT_DEAD_ZONE),
                   pick_zone(gaq_pkg::RST_RIGHT_DEAD_ZONE),
                   {8'($urandom), trig}, delay, period, {1'($urandom), dir});
        if ($urandom_range(0, 2) == 0) write_reg(CFG_SPARE_HI, 16'($urandom));
    endtask

    task automatic test_reset_values();
        send_poll(make_poll(1'b1, 16'h0000, '0, '0, '0, '0, 8'd0, 8'd0));
        send_poll(make_poll(1'b1, 16'hFFFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF,
                            8'd255, 8'd255));
        send_poll(make_poll(1'b1, 16'hFFFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF,
                            8'd255, 8'd255));
        send_poll(make_poll(1'b1, 16'h0C00, 16'sd7849, '0, '0, 16'sd8688, 8'd30, 8'd31));
        send_poll(make_poll(1'b1, 16'h0000, 16'sd7848, '0, '0, -16'sd8689, 8'd29, 8'd0));
        send_poll(make_poll(1'b1, 16'h0001, '0, 16'sd16384, -16'sd16384, '0, 8'd0, 8'd0));
        send_poll(make_poll(1'b1, 16'h8001, 16'sd16385, -16'sd16385, -16'sd16385, 16'sd16385,
                            8'd0, 8'd0));
        send_poll(make_poll(1'b0, 16'hFFFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                            8'd255, 8'd255));
        send_poll(make_poll(1'b1, 16'h8001, 16'sd16385, -16'sd16385, -16'sd16385, 16'sd16385,
                            8'd0, 8'd0));
    endtask

    task automatic test_register_extremes();
        settle();
        set_config(16'd46341, 16'd46341, 16'd255, 16'hFFFF, 16'hFFFF, 16'h7FFF);
        send_poll(make_poll(1'b1, 16'h1000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                            8'd255, 8'd254));
        send_poll(make_poll(1'b1, 16'h1000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF,
                            8'd255, 8'd0));
        settle();
        set_config(16'd46340, 16'd46340, 16'd0, 16'd1, 16'd1, 16'h7FFF);
        send_poll(make_poll(1'b1, 16'h1000, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh8000,
                            8'd0, 8'd1));
        send_poll(make_poll(1'b1, 16'h1000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
                            8'd0, 8'd1));
        settle();
        set_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        repeat (4) send_poll(make_poll(1'b1, 16'h2000, '0, '0, 16'sd1, -16'sd1, 8'd0, 8'd1));
        settle();
        write_reg(CFG_SPARE_LO, 16'($urandom));
        write_reg(CFG_SPARE_HI, 16'($urandom));
        send_poll(make_poll(1'b1, 16'h2000, '0, '0, 16'sd1, -16'sd1, 8'd0, 8'd1));
    endtask

    task automatic test_typematic_repeat();
        settle();
        set_config(gaq_pkg::RST_LEFT_DEAD_ZONE, gaq_pkg::RST_RIGHT_DEAD_ZONE,
                   16'(gaq_pkg::RST_TRIGGER_THRESHOLD), 16'd5, 16'd3,
                   16'(gaq_pkg::RST_DIRECTION_THRESHOLD));
        cur = make_poll(1'b1, 16'hF00F, 16'sd20000, '0, '0, -16'sd20000, 8'd200, 8'd40);
        for (int i = 0; i < 40; i++)
        begin
            if (i % 13 == 12) cur.button_word ^= 16'(1) << $urandom_range(0, 15);
            send_poll(cur);
        end
        cur = make_poll(1'b1, 16'h0000, '0, '0, '0, '0, 8'd0, 8'd0);
        send_poll(cur);
    endtask

    task automatic test_result_backpressure();
        settle();
        steady = 1'b1;
        hold_request = HOLD_OFF;
        repeat (30)
        begin
            evolve_poll();
            send_poll(cur);
        end
        steady = 1'b0;
    endtask

    task automatic test_random_play();
        for (int phase = 0; phase < 9; phase++)
        begin
            settle();
            if (phase == 0)
                set_config(gaq_pkg::RST_LEFT_DEAD_ZONE, gaq_pkg::RST_RIGHT_DEAD_ZONE,
                           16'(gaq_pkg::RST_TRIGGER_THRESHOLD), gaq_pkg::RST_REPEAT_DELAY,
                           gaq_pkg::RST_REPEAT_PERIOD,
                           16'(gaq_pkg::RST_DIRECTION_THRESHOLD));
            else if (phase == 1)
                set_config(16'd0, 16'hFFFF, 16'd255, 16'd1, 16'd0, 16'h7FFF);
            else
                shuffle_config();
            steady = (phase % 3 == 2);
            repeat (50)
            begin
                evolve_poll();
                send_poll(cur);
            end
        end
        steady = 1'b0;
    endtask

    initial
    begin : result_sink
        int stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (result_valid && result_ready) check_report(result);
            if (hold_request > 0)
            begin
                stall = hold_request;
                hold_request = 0;
            end
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                stall--;
            end
            else
            begin
                result_ready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((poll_valid && poll_ready) || (result_valid && result_ready)) quiet = 0;
            else quiet++;
        end
        $display("gamepad_input_qualifier: mismatch");
        $finish;
    end

    initial
    begin : sequencer
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_values();
        test_register_extremes();
        test_typematic_repeat();
        test_result_backpressure();
        test_random_play();
        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_reports.size() == 0)
            $display("gamepad_input_qualifier: match");
        else
            $display("gamepad_input_qualifier: mismatch");
        $finish;
    end

endmodule
